/* src/assert_macros.svh */
// assertion macros shared by the rotor model rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/prltt_pkg.sv */
// shared types, step codes, register indexes and the exp table of the rotor model
package prltt_pkg;

  // exp(-x) table over 0 <= x <= 16
  localparam int EXP_TABLE_DEPTH = 64;
  localparam int EXP_SPAN        = 16;
  localparam int IDX_W           = $clog2(EXP_TABLE_DEPTH);
  localparam int TAB_AW          = $clog2(EXP_TABLE_DEPTH + 1);
  localparam logic [63:0] Q30_ONE = 64'h4000_0000;

  typedef logic [16:0]       exp_val_t;
  typedef logic [TAB_AW-1:0] tab_addr_t;
  typedef exp_val_t          exp_tab_t [0:EXP_TABLE_DEPTH];

  // constant divider for n^2 = rpm^2 / 60^2
  localparam int SEC_PER_MIN = 60;
  localparam int RPM_SQ_DIV  = SEC_PER_MIN * SEC_PER_MIN;
  localparam int DIV_REM_W   = $clog2(RPM_SQ_DIV);
  localparam int SQ_W        = 64;
  localparam int DIV_DIGIT   = 8;
  localparam int DIV_STEPS   = SQ_W / DIV_DIGIT;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);

  localparam logic [16:0] ONE_Q16    = 17'h1_0000;
  localparam logic [32:0] ONE_Q32    = 33'h1_0000_0000;
  localparam logic [47:0] THRUST_MAX = 48'hFFFF_FFFF_FFFF;
  localparam logic [46:0] TORQUE_MAX = 47'h7FFF_FFFF_FFFF;

  // configuration register indexes
  localparam int CFG_IDX_W = 4;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_BATTERY_VOLTAGE    = 4'd0;
  localparam cfg_idx_t CFG_MOTOR_KV           = 4'd1;
  localparam cfg_idx_t CFG_ROTATION_DIRECTION = 4'd2;
  localparam cfg_idx_t CFG_PROPELLER_DIAMETER = 4'd3;
  localparam cfg_idx_t CFG_THRUST_COEFFICIENT = 4'd4;
  localparam cfg_idx_t CFG_TORQUE_COEFFICIENT = 4'd5;
  localparam cfg_idx_t CFG_RESPONSE_RATE      = 4'd6;
  localparam cfg_idx_t CFG_INITIAL_RPM        = 4'd7;

  // datapath step codes, issued in this order
  typedef logic [4:0] step_t;
  localparam step_t S_TGT1 = 5'd0;
  localparam step_t S_TGT2 = 5'd1;
  localparam step_t S_X    = 5'd2;
  localparam step_t S_P    = 5'd3;
  localparam step_t S_TAB  = 5'd4;
  localparam step_t S_E1   = 5'd5;
  localparam step_t S_E2   = 5'd6;
  localparam step_t S_BL   = 5'd7;
  localparam step_t S_R1   = 5'd8;
  localparam step_t S_R2   = 5'd9;
  localparam step_t S_R3   = 5'd10;
  localparam step_t S_SQ   = 5'd11;
  localparam step_t S_D2   = 5'd12;
  localparam step_t S_D4   = 5'd13;
  localparam step_t S_D5   = 5'd14;
  localparam step_t S_C1   = 5'd15;
  localparam step_t S_KT   = 5'd16;
  localparam step_t S_C2   = 5'd17;
  localparam step_t S_KQ   = 5'd18;
  localparam step_t S_T00  = 5'd19;
  localparam step_t S_T01  = 5'd20;
  localparam step_t S_T10  = 5'd21;
  localparam step_t S_T11  = 5'd22;
  localparam step_t S_TS1  = 5'd23;
  localparam step_t S_TS2  = 5'd24;
  localparam step_t S_Q00  = 5'd25;
  localparam step_t S_Q01  = 5'd26;
  localparam step_t S_Q10  = 5'd27;
  localparam step_t S_Q11  = 5'd28;
  localparam step_t S_QS1  = 5'd29;
  localparam step_t S_QS2  = 5'd30;
  localparam step_t S_FIN  = 5'd31;

  typedef struct packed {
    logic  load;
    logic  step_en;
    step_t step;
    logic  div_start;
  } prltt_cmd_t;

  typedef struct packed {
    logic div_busy;
  } prltt_sts_t;

  // exp(-f) in q2.30 by a truncated series, clamped to [0, 1]
  function automatic logic [63:0] exp_neg_q30(input logic [63:0] f);
    logic [63:0]    term;
    longint signed  sum;
    term = Q30_ONE;
    sum  = longint'(Q30_ONE);
    for (int k = 1; k <= 20; k++) begin
      term = ((term * f) >> 30) / 64'(k);
      if ((k % 2) == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    if (sum > longint'(Q30_ONE)) sum = longint'(Q30_ONE);
    return 64'(sum);
  endfunction

  // table entry i = exp(-16*i/depth) in q.16, built at elaboration
  function automatic exp_tab_t build_exp_tab();
    exp_tab_t    tab;
    logic [63:0] e1;
    logic [63:0] num;
    logic [63:0] n;
    logic [63:0] rem;
    logic [63:0] s;
    logic [63:0] en;
    e1 = exp_neg_q30(Q30_ONE);
    for (int i = 0; i <= EXP_TABLE_DEPTH; i++) begin
      num = 64'(EXP_SPAN) * 64'(i);
      n   = num / 64'(EXP_TABLE_DEPTH);
      rem = num % 64'(EXP_TABLE_DEPTH);
      s   = exp_neg_q30((rem << 30) / 64'(EXP_TABLE_DEPTH));
      en  = Q30_ONE;
      for (longint j = 0; j < longint'(n); j++) begin
        en = (en * e1 + (Q30_ONE >> 1)) >> 30;
      end
      tab[i] = 17'((s * en + (64'd1 << 43)) >> 44);
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

/* src/prltt_div3600.sv */
// constant divider by 60 squared, eight quotient bits per cycle
module prltt_div3600 (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [prltt_pkg::SQ_W-1:0]   dividend,
  output logic                         busy,
  output logic [prltt_pkg::SQ_W-1:0]   quotient
);

  logic [prltt_pkg::SQ_W-1:0]      num;
  logic [prltt_pkg::SQ_W-1:0]      num_next;
  logic [prltt_pkg::DIV_REM_W-1:0] rem;
  logic [prltt_pkg::DIV_REM_W-1:0] rem_next;
  logic [prltt_pkg::DIV_CNT_W-1:0] cnt;

  // restoring steps; quotient bits shift in where dividend bits leave
  always_comb begin : digit
    logic [prltt_pkg::DIV_REM_W:0] t;
    num_next = num;
    rem_next = rem;
    for (int k = 0; k < prltt_pkg::DIV_DIGIT; k++) begin
      t        = {rem_next, num_next[prltt_pkg::SQ_W-1]};
      num_next = {num_next[prltt_pkg::SQ_W-2:0], 1'b0};
      if (t >= (prltt_pkg::DIV_REM_W+1)'(prltt_pkg::RPM_SQ_DIV)) begin
        t           = t - (prltt_pkg::DIV_REM_W+1)'(prltt_pkg::RPM_SQ_DIV);
        num_next[0] = 1'b1;
      end
      rem_next = t[prltt_pkg::DIV_REM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= prltt_pkg::DIV_CNT_W'(prltt_pkg::DIV_STEPS);
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
      rem <= '0;
    end else if (cnt != '0) begin
      num <= num_next;
      rem <= rem_next;
    end
  end

  assign busy     = (cnt != '0);
  assign quotient = num;

endmodule

/* src/prltt_datapath.sv */
// rotor model datapath: config registers, shared multiplier, operand and result registers
module prltt_datapath (
  input  logic                   clk,
  input  logic                   rst,
  input  prltt_pkg::prltt_cmd_t  cmd,
  output prltt_pkg::prltt_sts_t  sts,
  input  logic [55:0]            s_tdata,
  output logic [127:0]           m_tdata,
  input  logic                   cfg_we,
  input  prltt_pkg::cfg_idx_t    cfg_index,
  input  logic [31:0]            cfg_data
);

  // configuration
  logic [15:0] battery_voltage;
  logic [15:0] motor_kv;
  logic [1:0]  rotation_direction;
  logic [15:0] propeller_diameter;
  logic [15:0] thrust_coefficient;
  logic [15:0] torque_coefficient;
  logic [15:0] response_rate;
  logic [31:0] rotor_rpm;

  // captured item
  logic [16:0] throttle;
  logic [19:0] time_step;
  logic [15:0] air_density;

  // intermediates
  logic [32:0]                   t1;
  logic [31:0]                   target;
  logic [35:0]                   x;
  logic                          xbig;
  logic [31:0]                   fr;
  logic [prltt_pkg::IDX_W-1:0]   idx;
  logic [16:0]                   ta;
  logic [16:0]                   tb;
  logic [48:0]                   ea;
  logic [48:0]                   eb;
  logic [16:0]                   blend;
  logic [48:0]                   ra;
  logic [48:0]                   rb;
  logic [63:0]                   sq;
  logic [31:0]                   d2;
  logic [31:0]                   d4;
  logic [31:0]                   d5;
  logic [31:0]                   c1;
  logic [31:0]                   c2;
  logic [63:0]                   kt;
  logic [63:0]                   kq;
  logic [63:0]                   pp0;
  logic [63:0]                   pp1;
  logic [63:0]                   pp2;
  logic [63:0]                   pp3;
  logic [64:0]                   mid;
  logic [47:0]                   thrust_mag;
  logic [46:0]                   tq_mag;

  // result register
  logic [47:0] thrust_out;
  logic [47:0] torque_out;
  logic [31:0] rpm_out;

  logic [32:0]               mul_a;
  logic [32:0]               mul_b;
  logic [65:0]               prod;
  logic [49:0]               esum;
  logic [17:0]               e_val;
  logic [16:0]               e_clamp;
  logic [49:0]               rsum;
  logic [127:0]              full;
  logic [63:0]               n2;
  logic                      div_busy;
  prltt_pkg::tab_addr_t      tab_a0;
  prltt_pkg::tab_addr_t      tab_a1;

  prltt_div3600 u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (sq),
    .busy     (div_busy),
    .quotient (n2)
  );

  assign sts.div_busy = div_busy;

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.step)
      prltt_pkg::S_TGT1: begin mul_a = 33'(throttle);       mul_b = 33'(motor_kv);           end
      prltt_pkg::S_TGT2: begin mul_a = t1;                  mul_b = 33'(battery_voltage);    end
      prltt_pkg::S_X:    begin mul_a = 33'(response_rate);  mul_b = 33'(time_step);          end
      prltt_pkg::S_P:    begin
        mul_a = 33'(x[31:0]);
        mul_b = 33'(prltt_pkg::EXP_TABLE_DEPTH);
      end
      prltt_pkg::S_E1:   begin mul_a = 33'(ta);  mul_b = prltt_pkg::ONE_Q32 - 33'(fr);       end
      prltt_pkg::S_E2:   begin mul_a = 33'(tb);             mul_b = 33'(fr);                 end
      prltt_pkg::S_R1:   begin
        mul_a = 33'(rotor_rpm);
        mul_b = 33'(prltt_pkg::ONE_Q16 - blend);
      end
      prltt_pkg::S_R2:   begin mul_a = 33'(target);         mul_b = 33'(blend);              end
      prltt_pkg::S_SQ:   begin mul_a = 33'(rotor_rpm);      mul_b = 33'(rotor_rpm);          end
      prltt_pkg::S_D2:   begin mul_a = 33'(propeller_diameter); mul_b = 33'(propeller_diameter); end
      prltt_pkg::S_D4:   begin mul_a = 33'(d2);             mul_b = 33'(d2);                 end
      prltt_pkg::S_D5:   begin mul_a = 33'(d4);             mul_b = 33'(propeller_diameter); end
      prltt_pkg::S_C1:   begin mul_a = 33'(thrust_coefficient); mul_b = 33'(air_density);    end
      prltt_pkg::S_KT:   begin mul_a = 33'(c1);             mul_b = 33'(d4);                 end
      prltt_pkg::S_C2:   begin mul_a = 33'(torque_coefficient); mul_b = 33'(air_density);    end
      prltt_pkg::S_KQ:   begin mul_a = 33'(c2);             mul_b = 33'(d5);                 end
      prltt_pkg::S_T00:  begin mul_a = 33'(kt[31:0]);  mul_b = 33'(n2[31:0]);  end
      prltt_pkg::S_T01:  begin mul_a = 33'(kt[31:0]);  mul_b = 33'(n2[63:32]); end
      prltt_pkg::S_T10:  begin mul_a = 33'(kt[63:32]); mul_b = 33'(n2[31:0]);  end
      prltt_pkg::S_T11:  begin mul_a = 33'(kt[63:32]); mul_b = 33'(n2[63:32]); end
      prltt_pkg::S_Q00:  begin mul_a = 33'(kq[31:0]);  mul_b = 33'(n2[31:0]);  end
      prltt_pkg::S_Q01:  begin mul_a = 33'(kq[31:0]);  mul_b = 33'(n2[63:32]); end
      prltt_pkg::S_Q10:  begin mul_a = 33'(kq[63:32]); mul_b = 33'(n2[31:0]);  end
      prltt_pkg::S_Q11:  begin mul_a = 33'(kq[63:32]); mul_b = 33'(n2[63:32]); end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = {33'b0, mul_a} * {33'b0, mul_b};

  // interpolation sum, clamped to one
  assign esum    = {1'b0, ea} + {1'b0, eb};
  assign e_val   = esum[49:32];
  assign e_clamp = (e_val > 18'(prltt_pkg::ONE_Q16)) ? prltt_pkg::ONE_Q16 : e_val[16:0];

  assign rsum = {1'b0, ra} + {1'b0, rb};

  // 128-bit product from four partials
  assign full = {pp3, pp0} + {31'b0, mid, 32'b0};

  assign tab_a0 = prltt_pkg::tab_addr_t'(idx);
  assign tab_a1 = prltt_pkg::tab_addr_t'(idx) + prltt_pkg::tab_addr_t'(1);

  // configuration and rotor state
  always_ff @(posedge clk) begin
    if (rst) begin
      battery_voltage    <= '0;
      motor_kv           <= '0;
      rotation_direction <= '0;
      propeller_diameter <= '0;
      thrust_coefficient <= '0;
      torque_coefficient <= '0;
      response_rate      <= '0;
      rotor_rpm          <= '0;
    end else begin
      if (cmd.step_en && cmd.step == prltt_pkg::S_R3) begin
        rotor_rpm <= rsum[47:16];
      end
      if (cfg_we) begin
        case (cfg_index)
          prltt_pkg::CFG_BATTERY_VOLTAGE:    battery_voltage    <= cfg_data[15:0];
          prltt_pkg::CFG_MOTOR_KV:           motor_kv           <= cfg_data[15:0];
          prltt_pkg::CFG_ROTATION_DIRECTION: rotation_direction <= cfg_data[1:0];
          prltt_pkg::CFG_PROPELLER_DIAMETER: propeller_diameter <= cfg_data[15:0];
          prltt_pkg::CFG_THRUST_COEFFICIENT: thrust_coefficient <= cfg_data[15:0];
          prltt_pkg::CFG_TORQUE_COEFFICIENT: torque_coefficient <= cfg_data[15:0];
          prltt_pkg::CFG_RESPONSE_RATE:      response_rate      <= cfg_data[15:0];
          prltt_pkg::CFG_INITIAL_RPM:        rotor_rpm          <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // item capture and per-step results
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      throttle    <= s_tdata[16:0];
      time_step   <= s_tdata[36:17];
      air_density <= s_tdata[52:37];
    end
    if (cmd.step_en) begin
      case (cmd.step)
        prltt_pkg::S_TGT1: t1 <= prod[32:0];
        prltt_pkg::S_TGT2: target <= prod[48] ? 32'hFFFF_FFFF : prod[47:16];
        prltt_pkg::S_X:    x <= prod[35:0];
        prltt_pkg::S_P: begin
          xbig <= (x[35:32] != 4'd0);
          fr   <= prod[31:0];
          idx  <= prod[32 +: prltt_pkg::IDX_W];
        end
        prltt_pkg::S_TAB: begin
          ta <= prltt_pkg::EXP_TAB[tab_a0];
          tb <= prltt_pkg::EXP_TAB[tab_a1];
        end
        prltt_pkg::S_E1:  ea <= prod[48:0];
        prltt_pkg::S_E2:  eb <= prod[48:0];
        prltt_pkg::S_BL:  blend <= xbig ? prltt_pkg::ONE_Q16 : prltt_pkg::ONE_Q16 - e_clamp;
        prltt_pkg::S_R1:  ra <= prod[48:0];
        prltt_pkg::S_R2:  rb <= prod[48:0];
        prltt_pkg::S_SQ:  sq <= prod[63:0];
        prltt_pkg::S_D2:  d2 <= prod[31:0];
        prltt_pkg::S_D4:  d4 <= prod[63:32];
        prltt_pkg::S_D5:  d5 <= prod[47:16];
        prltt_pkg::S_C1:  c1 <= prod[31:0];
        prltt_pkg::S_KT:  kt <= prod[63:0];
        prltt_pkg::S_C2:  c2 <= prod[31:0];
        prltt_pkg::S_KQ:  kq <= prod[63:0];
        prltt_pkg::S_T00, prltt_pkg::S_Q00: pp0 <= prod[63:0];
        prltt_pkg::S_T01, prltt_pkg::S_Q01: pp1 <= prod[63:0];
        prltt_pkg::S_T10, prltt_pkg::S_Q10: pp2 <= prod[63:0];
        prltt_pkg::S_T11, prltt_pkg::S_Q11: pp3 <= prod[63:0];
        prltt_pkg::S_TS1, prltt_pkg::S_QS1: mid <= {1'b0, pp1} + {1'b0, pp2};
        prltt_pkg::S_TS2:
          thrust_mag <= (full[127:108] != '0) ? prltt_pkg::THRUST_MAX : full[107:60];
        prltt_pkg::S_QS2:
          tq_mag <= (full[127:107] != '0) ? prltt_pkg::TORQUE_MAX : full[106:60];
        prltt_pkg::S_FIN: begin
          thrust_out <= thrust_mag;
          rpm_out    <= rotor_rpm;
          // zero direction gives no torque; any negative code flips the sign
          if (rotation_direction == 2'b00) torque_out <= '0;
          else if (rotation_direction[1]) torque_out <= 48'd0 - {1'b0, tq_mag};
          else torque_out <= {1'b0, tq_mag};
        end
        default: ;
      endcase
    end
  end

  assign m_tdata = {rpm_out, torque_out, thrust_out};

endmodule

/* src/prltt_ctrl.sv */
// rotor model controller: accepts items, sequences datapath steps, owns the result valid
`include "assert_macros.svh"

module prltt_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output prltt_pkg::prltt_cmd_t  cmd,
  input  prltt_pkg::prltt_sts_t  sts
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic              state;
  prltt_pkg::step_t  step;
  logic              out_valid;
  logic              stall;
  logic              fin_go;

  // wait for the quotient, and for room in the result register
  assign stall = (step == prltt_pkg::S_T00 && sts.div_busy) ||
                 (step == prltt_pkg::S_FIN && out_valid && !m_tready);

  assign s_tready      = (state == ST_IDLE);
  assign cmd.load      = s_tvalid && s_tready;
  assign cmd.step_en   = (state == ST_RUN) && !stall;
  assign cmd.step      = step;
  assign cmd.div_start = (state == ST_RUN) && (step == prltt_pkg::S_D2);
  assign fin_go        = cmd.step_en && (step == prltt_pkg::S_FIN);
  assign m_tvalid      = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= prltt_pkg::S_TGT1;
      out_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (cmd.load) begin
            state <= ST_RUN;
            step  <= prltt_pkg::S_TGT1;
          end
        end
        ST_RUN: begin
          if (fin_go) state <= ST_IDLE;
          if (cmd.step_en) step <= prltt_pkg::step_t'(step + 1'b1);
        end
        default: state <= ST_IDLE;
      endcase
      if (fin_go) out_valid <= 1'b1;
      else if (m_tready) out_valid <= 1'b0;
    end
  end

  `ASSERT_IMPLIES(a_fin_room, fin_go, !out_valid || m_tready, "result overwritten")
  `ASSERT_IMPLIES(a_div_free, cmd.div_start, !sts.div_busy, "divider restarted while busy")
  `ASSERT_IMPLIES(a_quot_done, cmd.step_en && step == prltt_pkg::S_T00, !sts.div_busy,
                  "quotient used before done")
  `ASSERT_NEXT(a_accept_run, cmd.load, state == ST_RUN && step == prltt_pkg::S_TGT1,
               "accepted item did not start")

endmodule

/* src/propeller_rpm_lag_thrust_torque_unit.sv */
// top level of the propeller rotor speed lag and thrust/torque model
//
// Each input transaction (throttle, time step, air density) moves the kept rotor speed
// toward throttle*kv*voltage through a first-order lag taken from an interpolated exp
// table, then returns thrust, signed torque and the new rpm as one output transaction.
// An item is accepted while idle, then runs 32 sequenced steps and waits before the first
// thrust partial product until the rpm^2/3600 divider is done; a new item is not accepted
// before its last step. The time per item is set by the single shared 33x33 multiplier,
// which forms some two dozen products one per step, and by the divider, which yields eight
// quotient bits a cycle. The result sits in an output
// register, so the next item is accepted while it waits; a new result is only held back
// when the previous one has not yet been taken. Configuration writes are always ready,
// and are meant to be issued while no item is in flight; writing initial_rpm also loads
// the rotor speed.
module propeller_rpm_lag_thrust_torque_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [55:0]          s_tdata,   // throttle[16:0], time_step[36:17], air_density[52:37]
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [127:0]         m_tdata,   // thrust[47:0], torque[95:48], rpm[127:96]
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  prltt_pkg::cfg_idx_t  cfg_index,
  input  logic [31:0]          cfg_data
);

  prltt_pkg::prltt_cmd_t cmd;
  prltt_pkg::prltt_sts_t sts;

  assign cfg_ready = 1'b1;

  prltt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  prltt_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .s_tdata   (s_tdata),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule
